// ===== src/quadratic_probe_hash_insert_macros.svh =====
// Assertion macros shared by the quadratic-probe hash insert design.
`ifndef QUADRATIC_PROBE_HASH_INSERT_MACROS_SVH
`define QUADRATIC_PROBE_HASH_INSERT_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define QPHI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qphi: same-cycle check failed");

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define QPHI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qphi: next-cycle check failed");

`endif

// ===== src/qphi_pkg.sv =====
// Types, constants and codes of the quadratic-probe hash insert block.
package qphi_pkg;

  localparam int MAX_SLOTS = 128;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);

  localparam int SIZE_W  = 8;
  localparam int PHONE_W = 44;
  localparam int NAME_W  = 32;
  localparam int PROBE_W = 8;
  localparam int ENTRY_W = 8;
  localparam int SUM_W   = 15;
  localparam int HASH_W  = 8;
  localparam int IDX_W   = 7;

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = SIZE_W'(13);
  localparam logic [SIZE_W-1:0] MIN_SIZE       = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] MAX_SIZE       = SIZE_W'(MAX_SLOTS);

  localparam logic [HASH_W-1:0] ASCII_ZERO = HASH_W'(48);
  localparam logic [HASH_W-1:0] DIGIT_BASE = HASH_W'(10);

  // APB register map
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_TABLE_SIZE = REG_IDX_W'(0);

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_CLEAR  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_CLEARED  = 2'd2
  } status_e;

  typedef struct packed {
    req_e                req_type;
    logic [PHONE_W-1:0]  phone_bcd;
    logic [NAME_W-1:0]   name_id;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]    slot_index;
    logic [PROBE_W-1:0]  probe_count;
    status_e             status;
    logic [ENTRY_W-1:0]  entry_total;
    logic [SUM_W-1:0]    probe_total;
  } rsp_t;

  // one stored record
  typedef struct packed {
    logic [PHONE_W-1:0]  phone;
    logic [NAME_W-1:0]   name;
    logic [PROBE_W-1:0]  probes;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch accepted transaction
    logic div_step;   // one bit of the home-slot remainder
    logic probe_init; // start probing at the home slot
    logic probe_adv;  // move to the next probe slot
    logic commit;     // store record, update totals, load result
    logic full;       // load table-full result
    logic clear;      // zero totals, load cleared result
    logic wipe;       // mark one slot empty, step the sweep address
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic slot_free;
    logic probe_last;
    logic wipe_last;
  } sts_t;

endpackage

// ===== src/qphi_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface qphi_req_if import qphi_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface qphi_rsp_if import qphi_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== src/qphi_ctrl.sv =====
// Sequencing state machine for the quadratic-probe hash insert block.
module qphi_ctrl import qphi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  req_e req_type_i,
  output logic req_ready_o,
  input  logic rsp_ready_i,
  output logic rsp_valid_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam int CNT_W = $clog2(HASH_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HASH_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_INIT,
    ST_PROBE,
    ST_CLEAR,
    ST_WIPE
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ready_q, ready_d;
  logic             rsp_valid_q, rsp_valid_d;
  logic             out_free;

  assign out_free = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i && ready_q) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = (req_type_i == REQ_CLEAR) ? ST_CLEAR : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) state_d = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.probe_init = 1'b1;
        state_d          = ST_PROBE;
      end
      ST_PROBE: begin
        if (sts_i.slot_free || sts_i.probe_last) begin
          if (out_free) begin
            cmd_o.commit = sts_i.slot_free;
            cmd_o.full   = !sts_i.slot_free;
            rsp_valid_d  = 1'b1;
            state_d      = ST_IDLE;
          end
        end else begin
          cmd_o.probe_adv = 1'b1;
        end
      end
      ST_CLEAR: begin
        if (out_free) begin
          cmd_o.clear = 1'b1;
          rsp_valid_d = 1'b1;
          state_d     = ST_WIPE;
        end
      end
      // sweep every slot empty, one per cycle
      ST_WIPE: begin
        cmd_o.wipe = 1'b1;
        if (sts_i.wipe_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    ready_d = (state_d == ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WIPE;
      cnt_q       <= '0;
      ready_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ready_q     <= ready_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign req_ready_o = ready_q;
  assign rsp_valid_o = rsp_valid_q;

endmodule

// ===== src/qphi_dpath.sv =====
// Datapath: home-slot remainder, probe stepping, slot table, totals, result register.
module qphi_dpath import qphi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic [SIZE_W-1:0] table_size_i,
  input  req_t              req_i,
  output sts_t              sts_o,
  output rsp_t              rsp_o
);

  logic [SIZE_W-1:0]    sz;
  logic [PHONE_W-1:0]   phone_q;
  logic [NAME_W-1:0]    name_q;
  logic [HASH_W-1:0]    div_q, rem_q, rem_d, key;
  logic [HASH_W:0]      trial;
  logic [SIZE_W-1:0]    pos_q, neg_q, step_q, cur_q, cur_d;
  logic [SIZE_W-1:0]    pos_n, neg_n, step_n;
  logic [SIZE_W:0]      pos_sum, step_sum;
  logic [PROBE_W-1:0]   k_q;
  logic [SLOT_W-1:0]    wipe_q;
  logic                 taken_q;
  logic [ENTRY_W-1:0]   entry_q, entry_n;
  logic [SUM_W-1:0]     sum_q, sum_n;
  logic [SUM_W:0]       sum_wide;
  logic [SLOT_W-1:0]    cur_idx, rd_idx;
  rsp_t                 out_q;
  entry_t               mem [MAX_SLOTS];
  logic                 taken_mem [MAX_SLOTS];

  // clamp the programmed size into the usable range
  always_comb begin
    if (table_size_i < MIN_SIZE)      sz = MIN_SIZE;
    else if (table_size_i > MAX_SIZE) sz = MAX_SIZE;
    else                              sz = table_size_i;
  end

  // key = tens*10 + units; units digit goes through the ASCII round trip
  assign key = HASH_W'(HASH_W'(req_i.phone_bcd[7:4]) * DIGIT_BASE)
             + HASH_W'((HASH_W'(req_i.phone_bcd[3:0]) + ASCII_ZERO) - ASCII_ZERO);

  // restoring remainder, one dividend bit per step
  assign trial = {rem_q, div_q[HASH_W-1]};
  assign rem_d = (trial >= {1'b0, sz}) ? HASH_W'(trial - {1'b0, sz}) : trial[HASH_W-1:0];

  // next square offsets: pos += step, neg -= step, step += 2 (all mod sz)
  assign pos_sum  = {1'b0, pos_q} + {1'b0, step_q};
  assign pos_n    = (pos_sum >= {1'b0, sz}) ? SIZE_W'(pos_sum - {1'b0, sz})
                                            : pos_sum[SIZE_W-1:0];
  assign neg_n    = (neg_q >= step_q) ? neg_q - step_q : SIZE_W'(neg_q + sz - step_q);
  assign step_sum = {1'b0, step_q} + (SIZE_W+1)'(2);
  assign step_n   = (step_sum >= {1'b0, sz}) ? SIZE_W'(step_sum - {1'b0, sz})
                                             : step_sum[SIZE_W-1:0];

  // slot of the next cycle; its occupancy bit is read ahead from that address
  always_comb begin
    if (cmd_i.probe_init)     cur_d = SIZE_W'(rem_q);
    else if (cmd_i.probe_adv) cur_d = k_q[0] ? pos_n : neg_q;
    else                      cur_d = cur_q;
  end

  assign cur_idx = cur_q[SLOT_W-1:0];
  assign rd_idx  = cur_d[SLOT_W-1:0];

  assign sts_o.slot_free  = !taken_q;
  assign sts_o.probe_last = (k_q == PROBE_W'(sz));
  assign sts_o.wipe_last  = (wipe_q == '1);

  // saturating totals
  assign entry_n  = (entry_q == '1) ? entry_q : entry_q + ENTRY_W'(1);
  assign sum_wide = {1'b0, sum_q} + (SUM_W+1)'(k_q);
  assign sum_n    = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_q  <= '0;
      entry_q <= '0;
      sum_q   <= '0;
    end else begin
      if (cmd_i.wipe) wipe_q <= wipe_q + SLOT_W'(1);
      if (cmd_i.clear) begin
        entry_q <= '0;
        sum_q   <= '0;
      end else if (cmd_i.commit) begin
        entry_q <= entry_n;
        sum_q   <= sum_n;
      end
    end
  end

  // slot occupancy: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wipe) begin
      taken_mem[wipe_q] <= 1'b0;
    end else if (cmd_i.commit) begin
      taken_mem[cur_idx] <= 1'b1;
    end
    taken_q <= taken_mem[rd_idx];
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (cmd_i.load) begin
      phone_q <= req_i.phone_bcd;
      name_q  <= req_i.name_id;
      div_q   <= key;
      rem_q   <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_d;
      div_q <= {div_q[HASH_W-2:0], 1'b0};
    end
    if (cmd_i.probe_init) begin
      pos_q  <= SIZE_W'(rem_q);
      neg_q  <= SIZE_W'(rem_q);
      step_q <= SIZE_W'(1);
      k_q    <= PROBE_W'(1);
    end
    if (cmd_i.probe_adv) begin
      k_q <= k_q + PROBE_W'(1);
      if (k_q[0]) begin
        // next probe is even: home + (q+1)^2
        pos_q  <= pos_n;
        neg_q  <= neg_n;
        step_q <= step_n;
      end
    end
    if (cmd_i.commit) begin
      mem[cur_idx]      <= '{phone: phone_q, name: name_q, probes: k_q};
      out_q.slot_index  <= IDX_W'(cur_q);
      out_q.probe_count <= k_q;
      out_q.status      <= STATUS_INSERTED;
      out_q.entry_total <= entry_n;
      out_q.probe_total <= sum_n;
    end else if (cmd_i.full) begin
      out_q.slot_index  <= '0;
      out_q.probe_count <= k_q;
      out_q.status      <= STATUS_FULL;
      out_q.entry_total <= entry_q;
      out_q.probe_total <= sum_q;
    end else if (cmd_i.clear) begin
      out_q.slot_index  <= '0;
      out_q.probe_count <= '0;
      out_q.status      <= STATUS_CLEARED;
      out_q.entry_total <= '0;
      out_q.probe_total <= '0;
    end
  end

  assign rsp_o = out_q;

endmodule

// ===== src/quadratic_probe_hash_insert.sv =====
// Top level of the quadratic-probe hash insert engine.
//
// Takes one request transaction at a time: either an insert (11-digit BCD
// phone number plus a name handle) or a clear of the whole table. The home
// slot is (tens*10 + units) mod the clamped table size (2..128); collisions
// probe home+1, home-1, home+4, home-4, ... mod size. Each result gives
// the slot, the probes used, a status (inserted / full / cleared) and the
// running entry count and probe sum for average search length. An insert runs
// through an accept step, the home-slot remainder (bit-serial restoring
// divide), a setup step and the probe loop; the probe loop checks one slot
// per cycle against a slot-occupancy RAM whose read is issued ahead. Slot
// occupancy is emptied by a sweep of all 128 slots, one per cycle: right after
// reset (ready stays low during that sweep) and after each clear. A clear's
// result is loaded once the output register is free; the next request is
// taken only after the sweep that follows the clear has ended. The result
// sits in an output register, so a finished result may wait for the consumer
// while the next request is already being accepted and worked on. table_size
// is at APB byte address 0; write it only while the block is idle.
`include "quadratic_probe_hash_insert_macros.svh"

module quadratic_probe_hash_insert import qphi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  qphi_req_if.sink           req_i,
  qphi_rsp_if.source         rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [SIZE_W-1:0]    table_size_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  cmd_t                 cmd;
  sts_t                 sts;
  logic                 clear_rsp_ok;
  logic                 commit_rsp_ok;

  // --- config register ---------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_TABLE_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= TABLE_SIZE_RST;
    end else if (cfg_wr) begin
      table_size_q <= pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TABLE_SIZE: prdata = PDATA_W'(table_size_q);
      default:        prdata = '0;
    endcase
  end

  // --- controller: accept, divide, probe, deliver --------------------------
  qphi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.payload.req_type),
    .req_ready_o (req_i.ready),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // --- datapath: hash, probe offsets, table, totals, result register -------
  qphi_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .table_size_i (table_size_q),
    .req_i        (req_i.payload),
    .sts_o        (sts),
    .rsp_o        (rsp_o.payload)
  );

  // --- checks ---------------------------------------------------------------
  assign clear_rsp_ok  = rsp_o.valid && (rsp_o.payload.status == STATUS_CLEARED) &&
                         (rsp_o.payload.entry_total == '0) &&
                         (rsp_o.payload.probe_total == '0);
  assign commit_rsp_ok = rsp_o.valid && (rsp_o.payload.status == STATUS_INSERTED) &&
                         (rsp_o.payload.probe_count != '0) &&
                         (rsp_o.payload.entry_total != '0);

  // one transaction in flight: ready drops right after an accept
  `QPHI_ASSERT_NEXT(a_one_in_flight, req_i.valid && req_i.ready, !req_i.ready)
  // a clear shows up as an all-zero cleared result
  `QPHI_ASSERT_NEXT(a_clear_result, cmd.clear, clear_rsp_ok)
  // a stored record reports at least one probe and a nonzero entry count
  `QPHI_ASSERT_NEXT(a_commit_result, cmd.commit, commit_rsp_ok)

endmodule

// ===== verif/quadratic_probe_hash_insert_tb.sv =====
// Self-checking testbench for the quadratic-probe hash insert engine.
module quadratic_probe_hash_insert_tb;
  import qphi_pkg::*;

  // Cycles with no accepted transaction before the run is declared hung.
  localparam int IDLE_LIMIT    = 2000;
  localparam int HOLD_CYCLES   = 300;
  // Worst-case insert latency plus margin, waited out once at the end.
  localparam int SETTLE_CYCLES = 150;
  localparam int SUM_SAT       = 32767;
  localparam int ENTRY_SAT     = 255;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  qphi_req_if req_bus ();
  qphi_rsp_if rsp_bus ();

  quadratic_probe_hash_insert dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the table: occupancy flags, running totals and the size
  // register. Stored phone/name/probe values never feed a result, so only the
  // occupancy is tracked.
  // ---------------------------------------------------------------------------
  bit                slot_taken [MAX_SLOTS];
  int                held_entries;
  int                held_probe_sum;
  logic [SIZE_W-1:0] size_reg;

  rsp_t pending_results [$];   // expected results, oldest first
  int   mismatches;

  // Both sides run without gaps while this is set.
  bit steady_flow;
  // One-shot request to the receiver for a long hold-off.
  bit rsp_hold_pending;

  // ---------------------------------------------------------------------------
  // Predictor: applies one request to the shadow table and returns the result.
  // ---------------------------------------------------------------------------
  function automatic rsp_t place_record(req_t item);
    rsp_t r;
    int   sz;
    int   units;
    int   tens;
    int   home;
    int   q;
    int   off;
    int   slot;
    r = '0;
    if (item.req_type == REQ_CLEAR) begin
      foreach (slot_taken[i]) slot_taken[i] = 1'b0;
      held_entries   = 0;
      held_probe_sum = 0;
      r.status = STATUS_CLEARED;
      return r;
    end
    // Register value is clamped into the usable range.
    sz = int'(size_reg);
    if (sz < int'(MIN_SIZE)) sz = int'(MIN_SIZE);
    if (sz > MAX_SLOTS) sz = MAX_SLOTS;
    // ASCII correction of the units digit cancels out; non-BCD nibbles hash
    // at their binary value.
    units = int'(item.phone_bcd[3:0]);
    tens  = int'(item.phone_bcd[7:4]);
    home  = (tens * int'(DIGIT_BASE) + units) % sz;
    // Default to table full: slot 0, probes = size, totals untouched.
    r.status      = STATUS_FULL;
    r.slot_index  = '0;
    r.probe_count = PROBE_W'(sz);
    for (int k = 1; k <= sz; k++) begin
      // Offsets +1, -1, +4, -4, ... always measured from home.
      if (k == 1) begin
        slot = home;
      end else begin
        q   = k / 2;
        off = (q * q) % sz;
        if (k % 2 == 0) slot = (home + off) % sz;
        else slot = (home + sz - off) % sz;
      end
      if (!slot_taken[slot]) begin
        slot_taken[slot] = 1'b1;
        if (held_entries < ENTRY_SAT) held_entries++;
        held_probe_sum += k;
        if (held_probe_sum > SUM_SAT) held_probe_sum = SUM_SAT;
        r.status      = STATUS_INSERTED;
        r.slot_index  = IDX_W'(slot);
        r.probe_count = PROBE_W'(k);
        break;
      end
    end
    r.entry_total = ENTRY_W'(held_entries);
    r.probe_total = SUM_W'(held_probe_sum);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset and the watchdog.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Ends the run if no transaction of any kind moves before the idle count reaches IDLE_LIMIT.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || psel || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls, plus one long hold-off when requested.
  // Signals are sampled at the rising edge before any update of that edge.
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    rsp_bus.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (rsp_hold_pending) begin
        stall = HOLD_CYCLES;
        rsp_hold_pending = 1'b0;
      end else begin
        stall = steady_flow ? 0 : $urandom_range(0, 10);
      end
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_bus.valid);
    end
  end

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // Each result transaction is compared with the oldest expectation.
  always @(posedge clk_i) begin
    rsp_t want;
    rsp_t got;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      got = rsp_bus.payload;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: slot_index %0d status %0d",
               got.slot_index, got.status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("slot_index", 32'(want.slot_index), 32'(got.slot_index));
        check_field("probe_count", 32'(want.probe_count), 32'(got.probe_count));
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("entry_total", 32'(want.entry_total), 32'(got.entry_total));
        check_field("probe_total", 32'(want.probe_total), 32'(got.probe_total));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side. Every task below is entered and left right after a rising
  // edge, so valid gets at most one update per edge.
  // ---------------------------------------------------------------------------
  task automatic send_request(input req_e op, input logic [PHONE_W-1:0] phone,
                              input logic [NAME_W-1:0] name);
    int   gap;
    req_t item;
    gap = steady_flow ? 0 : $urandom_range(0, 10);
    item.req_type  = op;
    item.phone_bcd = phone;
    item.name_id   = name;
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid   <= 1'b1;
    req_bus.payload <= item;
    do @(posedge clk_i); while (!req_bus.ready);
    pending_results.push_back(place_record(item));
  endtask

  // Mostly inserts; about half the keys get BCD-valid low digits.
  task automatic send_random_item();
    req_e              op;
    logic [PHONE_W-1:0] phone;
    op    = ($urandom_range(0, 14) == 0) ? REQ_CLEAR : REQ_INSERT;
    phone = PHONE_W'({$urandom, $urandom});
    if ($urandom_range(0, 1))
      phone[7:0] = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    send_request(op, phone, NAME_W'($urandom));
  endtask

  // Lets all results drain; the block is then idle or in a clear's sweep.
  task automatic drain_results();
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_table_size(input logic [SIZE_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TABLE_SIZE, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    size_reg = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drain, then reprogram the size.
  task automatic resize_table(input logic [SIZE_W-1:0] value);
    drain_results();
    write_table_size(value);
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests.
  // ---------------------------------------------------------------------------

  // Reset size, extreme keys and names (all-ones key has non-BCD nibbles).
  task automatic test_home_slot();
    send_request(REQ_INSERT, '0, '0);
    send_request(REQ_INSERT, '1, '1);
    send_request(REQ_INSERT, 44'h139_1234_5678, 32'hA5A5_0001);
  endtask

  // Same key over and over walks the +1, -1, +4, -4 chain; duplicates are
  // stored as new records.
  task automatic test_collisions();
    for (int i = 0; i < 4; i++)
      send_request(REQ_INSERT, 44'h138_0013_8099, NAME_W'(i));
  endtask

  // Clear on a loaded table, clear on an empty one, then insert again.
  task automatic test_clear();
    send_request(REQ_CLEAR, '1, '1);
    send_request(REQ_CLEAR, '0, '0);
    send_request(REQ_INSERT, 44'h186_0000_0042, 32'h0000_0042);
  endtask

  // Smallest table fills after two records; sizes 0 and 1 clamp to 2.
  task automatic test_table_full();
    resize_table(SIZE_W'(2));
    send_request(REQ_INSERT, 44'h150_0000_0005, 32'h1);
    send_request(REQ_INSERT, 44'h150_0000_0027, 32'h2);
    send_request(REQ_INSERT, 44'h150_0000_0099, 32'h3);
    resize_table(SIZE_W'(0));
    send_request(REQ_INSERT, 44'h150_0000_0010, 32'h4);
    resize_table(SIZE_W'(1));
    send_request(REQ_INSERT, 44'h150_0000_0011, 32'h5);
    send_request(REQ_CLEAR, '0, '0);
  endtask

  // Oversized register clamps to 128; resizing keeps the records already
  // stored, so low slots filled at size 5 collide again at size 128.
  task automatic test_size_extremes();
    resize_table(SIZE_W'(255));
    send_request(REQ_INSERT, '1, 32'h10);
    send_request(REQ_INSERT, '1, 32'h11);
    resize_table(SIZE_W'(5));
    send_request(REQ_INSERT, 44'h177_0000_0003, 32'h12);
    send_request(REQ_INSERT, 44'h177_0000_0008, 32'h13);
    send_request(REQ_INSERT, 44'h177_0000_0013, 32'h14);
    resize_table(SIZE_W'(MAX_SLOTS));
    send_request(REQ_INSERT, 44'h177_0000_0003, 32'h15);
  endtask

  // Receiver stops for a long stretch while the sender keeps offering
  // back-to-back transactions, so the block backs up and drops ready.
  task automatic test_backpressure();
    resize_table(SIZE_W'(13));
    rsp_hold_pending = 1'b1;
    steady_flow = 1'b1;
    for (int i = 0; i < 12; i++) send_random_item();
    steady_flow = 1'b0;
  endtask

  // Random phases over several sizes, two of them without any gaps.
  task automatic test_random();
    logic [SIZE_W-1:0] phase_sizes [10];
    phase_sizes = '{8'd13, 8'd2, 8'd128, 8'd7, 8'd0, 8'd255, 8'd31, 8'd1,
                    8'd64, 8'd3};
    foreach (phase_sizes[p]) begin
      resize_table(phase_sizes[p]);
      steady_flow = (p == 3 || p == 7);
      for (int i = 0; i < 40; i++) send_random_item();
    end
    steady_flow = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed tests, random phases, drain and settle.
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    req_bus.valid   <= 1'b0;
    req_bus.payload <= '0;
    steady_flow      = 1'b0;
    rsp_hold_pending = 1'b0;
    mismatches       = 0;
    held_entries     = 0;
    held_probe_sum   = 0;
    size_reg         = TABLE_SIZE_RST;
    foreach (slot_taken[i]) slot_taken[i] = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_home_slot();
    test_collisions();
    test_clear();
    test_table_full();
    test_size_extremes();
    test_backpressure();
    test_random();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
